// ----- rtl/core/message_mailbox_queue_with_full_policy_core_defines.svh -----
// ----------------------------------------------------------------------------
// Message mailbox queue assertion macros
// Shared concurrent assertion forms used by the queue checker.
// ----------------------------------------------------------------------------
`ifndef MESSAGE_MAILBOX_QUEUE_WITH_FULL_POLICY_CORE_DEFINES_SVH
`define MESSAGE_MAILBOX_QUEUE_WITH_FULL_POLICY_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define MMQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define MMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/mmq_pkg.sv -----
// ----------------------------------------------------------------------------
// Message mailbox queue package
// Field widths, status codes, action codes and register indexes.
// ----------------------------------------------------------------------------
package mmq_pkg;

    // Fixed field widths
    localparam int CAP_W    = 5;
    localparam int STATUS_W = 3;
    localparam int MSG_W    = 64;

    // Capacity register reset value
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Full-queue policy
    localparam logic POLICY_DROP_OLDEST = 1'b1;

    // Item actions
    localparam logic ACT_ENQUEUE = 1'b0;
    localparam logic ACT_DEQUEUE = 1'b1;

    // Configuration register indexes
    localparam logic REG_QUEUE_CAPACITY = 1'b0;
    localparam logic REG_FULL_POLICY    = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_STORED   = 3'd0,
        ST_DROPPED  = 3'd1,
        ST_REJECTED = 3'd2,
        ST_DEQUEUED = 3'd3,
        ST_EMPTY    = 3'd4
    } status_t;

endpackage

// ----- rtl/core/mmq_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mmq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write the addressed entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Register the read data
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/message_mailbox_queue_with_full_policy_core.sv -----
// ----------------------------------------------------------------------------
// Message mailbox queue core
// Circular message queue with programmable capacity and full-queue policy.
// ----------------------------------------------------------------------------
// The core takes one item per clock: busy is always low, so an item is taken
// at every edge where start is high. Each item gives exactly one result,
// shown with done for the single cycle that follows the accepting edge; the
// receiver cannot stall it. The read word comes from the registered
// read port of the slot memory. Status, pointer and count updates finish at
// the accepting edge, so back-to-back items see each other's effects. Slot
// contents are not cleared at reset and there is no clearing pass.
// Configuration is written through cfg_write, cfg_index and cfg_data, and
// should only change while no item is in flight.
// ----------------------------------------------------------------------------
module message_mailbox_queue_with_full_policy_core #(
    parameter int MAX_DEPTH = 16,
    parameter int WORD_BITS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Item input
    input  logic                          start,
    output logic                          busy,
    input  logic                          action,
    input  logic [mmq_pkg::MSG_W-1:0]     message_word,
    // Result output
    output logic                          done,
    output logic [mmq_pkg::STATUS_W-1:0]  status,
    output logic [WORD_BITS-1:0]          read_word,
    output logic [mmq_pkg::CAP_W-1:0]     fill_level,
    // Configuration write port
    input  logic                          cfg_write,
    input  logic                          cfg_index,
    input  logic [mmq_pkg::CAP_W-1:0]     cfg_data
);

    import mmq_pkg::*;

    localparam int IDX_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int SUM_W     = ((IDX_W > CAP_W) ? IDX_W : CAP_W) + 1;
    localparam int CAP_LIMIT = (MAX_DEPTH < 31) ? MAX_DEPTH : 31;
    localparam logic [CAP_W-1:0] CAP_LIMIT_V = CAP_W'(CAP_LIMIT);
    localparam logic [CAP_W-1:0] CAP_ONE     = CAP_W'(1);

    // Configuration registers
    logic [CAP_W-1:0] queue_capacity_reg;
    logic             full_policy_reg;

    // Queue state
    logic [IDX_W-1:0] read_index_reg,  read_index_next;
    logic [IDX_W-1:0] write_index_reg, write_index_next;
    logic [CAP_W-1:0] stored_count_reg, stored_count_next;

    // Result registers
    logic             done_reg;
    logic             deq_reg,    deq_next;
    status_t          status_reg, status_next;
    logic [CAP_W-1:0] fill_reg;

    // Memory controls
    logic                 accept;
    logic                 ram_we;
    logic                 ram_re;
    logic [WORD_BITS-1:0] ram_rdata;
    logic [CAP_W-1:0]     cap_eff;
    logic                 queue_full;

    // Step an index, wrapping at the effective capacity
    function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
                                                 input logic [CAP_W-1:0] cap);
        logic [SUM_W-1:0] nxt;
        nxt = SUM_W'(idx) + SUM_W'(1);
        if (nxt >= SUM_W'(cap))
        begin
            advance = '0;
        end
        else
        begin
            advance = nxt[IDX_W-1:0];
        end
    endfunction

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Clamp capacity into 1..MAX_DEPTH, and never above 31
    always_comb
    begin
        if (queue_capacity_reg == '0)
        begin
            cap_eff = CAP_ONE;
        end
        else if (queue_capacity_reg > CAP_LIMIT_V)
        begin
            cap_eff = CAP_LIMIT_V;
        end
        else
        begin
            cap_eff = queue_capacity_reg;
        end
    end

    assign queue_full = (stored_count_reg >= cap_eff);

    // Decide the item outcome and next queue state
    always_comb
    begin
        read_index_next   = read_index_reg;
        write_index_next  = write_index_reg;
        stored_count_next = stored_count_reg;
        status_next       = ST_STORED;
        deq_next          = 1'b0;
        ram_we            = 1'b0;
        ram_re            = 1'b0;
        if (accept)
        begin
            case (action)
                ACT_ENQUEUE:
                begin
                    if (queue_full && (full_policy_reg != POLICY_DROP_OLDEST))
                    begin
                        status_next = ST_REJECTED;
                    end
                    else
                    begin
                        ram_we           = 1'b1;
                        write_index_next = advance(write_index_reg, cap_eff);
                        if (queue_full)
                        begin
                            // Drop the oldest; the count stays the same
                            read_index_next = advance(read_index_reg, cap_eff);
                            status_next     = ST_DROPPED;
                        end
                        else
                        begin
                            stored_count_next = stored_count_reg + CAP_W'(1);
                            status_next       = ST_STORED;
                        end
                    end
                end
                ACT_DEQUEUE:
                begin
                    if (stored_count_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        ram_re            = 1'b1;
                        deq_next          = 1'b1;
                        read_index_next   = advance(read_index_reg, cap_eff);
                        stored_count_next = stored_count_reg - CAP_W'(1);
                        status_next       = ST_DEQUEUED;
                    end
                end
                default:
                begin
                    status_next = ST_STORED;
                end
            endcase
        end
    end

    // Hold configuration, write on request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            queue_capacity_reg <= CAP_RESET;
            full_policy_reg    <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_QUEUE_CAPACITY: queue_capacity_reg <= cfg_data;
                REG_FULL_POLICY:    full_policy_reg    <= cfg_data[0];
                default:            full_policy_reg    <= full_policy_reg;
            endcase
        end
    end

    // Advance queue state and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_index_reg   <= '0;
            write_index_reg  <= '0;
            stored_count_reg <= '0;
            done_reg         <= 1'b0;
            deq_reg          <= 1'b0;
        end
        else
        begin
            read_index_reg   <= read_index_next;
            write_index_reg  <= write_index_next;
            stored_count_reg <= stored_count_next;
            done_reg         <= accept;
            deq_reg          <= deq_next;
        end
    end

    // Capture result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            fill_reg   <= stored_count_next;
        end
    end

    // Slot storage
    mmq_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAX_DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (write_index_reg),
        .wdata (message_word[WORD_BITS-1:0]),
        .re    (ram_re),
        .raddr (read_index_reg),
        .rdata (ram_rdata)
    );

    // Drive result ports
    assign done       = done_reg;
    assign status     = status_reg;
    assign fill_level = fill_reg;
    assign read_word  = deq_reg ? ram_rdata : '0;

endmodule

// ----- rtl/core/mmq_checker.sv -----
// ----------------------------------------------------------------------------
// Message mailbox queue checker
// Port-level assertions on item acceptance and result contents.
// ----------------------------------------------------------------------------
`include "message_mailbox_queue_with_full_policy_core_defines.svh"

module mmq_checker #(
    parameter int WORD_BITS = 64
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          done,
    input logic [mmq_pkg::STATUS_W-1:0]  status,
    input logic [WORD_BITS-1:0]          read_word,
    input logic [mmq_pkg::CAP_W-1:0]     fill_level
);

    import mmq_pkg::*;

    // Every accepted item yields a result in the next cycle
    `MMQ_ASSERT_NEXT(a_result_follows, clk, rst_n, start && !busy, done, "missing result")

    // No result without an item
    `MMQ_ASSERT_NEXT(a_no_spurious, clk, rst_n, !(start && !busy), !done, "spurious result")

    // Read data is zero unless a message was dequeued
    `MMQ_ASSERT_NOW(a_read_zero, clk, rst_n, done && (status != ST_DEQUEUED), read_word == '0, "read data not zero")

    // An empty report leaves nothing held, a drop leaves the queue non-empty
    `MMQ_ASSERT_NOW(a_fill_consistent, clk, rst_n, done && ((status == ST_EMPTY) || (status == ST_DROPPED)), (status == ST_EMPTY) == (fill_level == '0), "fill level mismatch")

endmodule

bind message_mailbox_queue_with_full_policy_core mmq_checker #(
    .WORD_BITS (WORD_BITS)
) u_mmq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .status     (status),
    .read_word  (read_word),
    .fill_level (fill_level)
);

// ----- tb/message_mailbox_queue_with_full_policy_core_checker.sv -----
// ----------------------------------------------------------------------------
// Message mailbox queue checker
// Watches the item, result and register-write ports of the queue core and
// keeps its own copy of the queue state and registers. It predicts the reply
// of every accepted item and compares each done strobe, field by field, with
// the oldest predicted reply. The mismatch count and the number of replies
// still in flight are handed to the testbench top.
// ----------------------------------------------------------------------------
module message_mailbox_queue_with_full_policy_core_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          action,
    input  logic [mmq_pkg::MSG_W-1:0]     message_word,
    input  logic                          done,
    input  logic [mmq_pkg::STATUS_W-1:0]  status,
    input  logic [mmq_pkg::MSG_W-1:0]     read_word,
    input  logic [mmq_pkg::CAP_W-1:0]     fill_level,
    input  logic                          cfg_write,
    input  logic                          cfg_index,
    input  logic [mmq_pkg::CAP_W-1:0]     cfg_data,
    output int                            mismatches,
    output int                            outstanding,
    output int                            replies_checked,
    output logic [4:0]                    statuses_seen
);
    import mmq_pkg::*;

    localparam int SLOT_COUNT = 16;

    typedef struct packed {
        status_t            code;
        logic [MSG_W-1:0]   word;
        logic [CAP_W-1:0]   fill;
    } mailbox_reply_t;

    // Predicted replies, oldest first
    mailbox_reply_t pending_replies[$];

    // Shadow queue state and registers
    logic [MSG_W-1:0]   slot_copy [SLOT_COUNT];
    logic [3:0]         head_idx;
    logic [3:0]         tail_idx;
    logic [CAP_W-1:0]   held;
    logic [CAP_W-1:0]   capacity_reg;
    logic               policy_reg;

    mailbox_reply_t     reply;
    mailbox_reply_t     oldest;
    logic [CAP_W-1:0]   cap;

    // Clamp the capacity register to 1..SLOT_COUNT
    function automatic logic [CAP_W-1:0] usable_capacity(input logic [CAP_W-1:0] reg_value);
        if (reg_value == 0)
            return CAP_W'(1);
        if (reg_value > SLOT_COUNT)
            return CAP_W'(SLOT_COUNT);
        return reg_value;
    endfunction

    // Step an index, wrapping at the capacity
    function automatic logic [3:0] next_slot(input logic [3:0] idx, input logic [CAP_W-1:0] c);
        logic [CAP_W-1:0] n;
        n = {1'b0, idx} + 5'd1;
        return (n >= c) ? 4'd0 : n[3:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_replies.delete();
            head_idx        = '0;
            tail_idx        = '0;
            held            = '0;
            capacity_reg    = CAP_RESET;
            policy_reg      = 1'b0;
            mismatches      = 0;
            outstanding     = 0;
            replies_checked = 0;
            statuses_seen   = '0;
            for (int i = 0; i < SLOT_COUNT; i++)
                slot_copy[i] = '0;
        end
        else
        begin
            // Compare a reply with the oldest prediction
            if (done === 1'b1)
            begin
                if (pending_replies.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: reply with no item waiting: status %0d read_word %h fill %0d",
                             $time, status, read_word, fill_level);
                end
                else
                begin
                    oldest = pending_replies.pop_front();
                    replies_checked++;
                    if (status <= ST_EMPTY)
                        statuses_seen[status] = 1'b1;
                    if (status !== oldest.code)
                    begin
                        mismatches++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, oldest.code, status);
                    end
                    if (read_word !== oldest.word)
                    begin
                        mismatches++;
                        $display("%0t: read_word expected %h actual %h",
                                 $time, oldest.word, read_word);
                    end
                    if (fill_level !== oldest.fill)
                    begin
                        mismatches++;
                        $display("%0t: fill_level expected %0d actual %0d",
                                 $time, oldest.fill, fill_level);
                    end
                end
            end

            // Track register writes
            if (cfg_write === 1'b1)
            begin
                case (cfg_index)
                    REG_QUEUE_CAPACITY: capacity_reg = cfg_data;
                    REG_FULL_POLICY:    policy_reg   = cfg_data[0];
                    default: ;
                endcase
            end

            // Predict the reply of an accepted item
            if (start === 1'b1 && busy === 1'b0)
            begin
                cap        = usable_capacity(capacity_reg);
                reply.word = '0;
                if (action == ACT_ENQUEUE)
                begin
                    reply.code = ST_STORED;
                    if (held >= cap)
                    begin
                        if (policy_reg == POLICY_DROP_OLDEST)
                        begin
                            head_idx   = next_slot(head_idx, cap);
                            held       = held - 1'b1;
                            reply.code = ST_DROPPED;
                        end
                        else
                            reply.code = ST_REJECTED;
                    end
                    if (reply.code != ST_REJECTED)
                    begin
                        slot_copy[tail_idx] = message_word;
                        tail_idx            = next_slot(tail_idx, cap);
                        held                = held + 1'b1;
                    end
                end
                else if (held == 0)
                    reply.code = ST_EMPTY;
                else
                begin
                    reply.word = slot_copy[head_idx];
                    head_idx   = next_slot(head_idx, cap);
                    held       = held - 1'b1;
                    reply.code = ST_DEQUEUED;
                end
                reply.fill = held;
                pending_replies.push_back(reply);
            end

            outstanding = pending_replies.size();
        end
    end

endmodule

// ----- tb/message_mailbox_queue_with_full_policy_core_test.sv -----
// ----------------------------------------------------------------------------
// Message mailbox queue testbench
// Drives the queue core with a directed opening (empty dequeue, fill to the
// full capacity, reject, drop-oldest, clamped capacities) and then random
// phases of enqueue and dequeue items under random capacity and policy
// settings, changed while messages are still held. The checker beside the
// core predicts and compares every reply; this top gives the verdict.
// ----------------------------------------------------------------------------
module message_mailbox_queue_with_full_policy_core_test;
    import mmq_pkg::*;

    localparam int RANDOM_ITEMS = 1600;
    localparam int STALL_LIMIT  = 2000;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic                  action;
    logic [MSG_W-1:0]      message_word;
    logic                  done;
    logic [STATUS_W-1:0]   status;
    logic [MSG_W-1:0]      read_word;
    logic [CAP_W-1:0]      fill_level;
    logic                  cfg_write;
    logic                  cfg_index;
    logic [CAP_W-1:0]      cfg_data;

    int                    mismatches;
    int                    outstanding;
    int                    replies_checked;
    logic [4:0]            statuses_seen;

    int                    idle_pct;
    int                    items_sent;
    int                    settings_applied;
    int                    stall_cycles;

    message_mailbox_queue_with_full_policy_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .message_word (message_word),
        .done         (done),
        .status       (status),
        .read_word    (read_word),
        .fill_level   (fill_level),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    message_mailbox_queue_with_full_policy_core_checker mailbox_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .action          (action),
        .message_word    (message_word),
        .done            (done),
        .status          (status),
        .read_word       (read_word),
        .fill_level      (fill_level),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .replies_checked (replies_checked),
        .statuses_seen   (statuses_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Pick a message word, biased toward all zeros and all ones
    function automatic logic [MSG_W-1:0] pick_word();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Offer one item, idling at random first; return at the next falling edge
    task automatic send_item(input logic act, input logic [MSG_W-1:0] word);
        while ($urandom_range(99) < idle_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start        = 1'b1;
        action       = act;
        message_word = word;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        items_sent++;
        @(negedge clk);
    endtask

    // Hold off items until every predicted reply has come back
    task automatic drain_replies();
        start = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // Write one register; the queue must be idle
    task automatic write_reg(input logic idx, input logic [CAP_W-1:0] data);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_write = 1'b0;
        settings_applied++;
    endtask

    // Watchdog: end the run when nothing moves for too long
    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int phase_idx;
        int phase_len;
        int enq_pct;
        int target;
        logic [CAP_W-1:0] cap_value;

        rst_n            = 1'b0;
        start            = 1'b0;
        action           = ACT_ENQUEUE;
        message_word     = '0;
        cfg_write        = 1'b0;
        cfg_index        = REG_QUEUE_CAPACITY;
        cfg_data         = '0;
        idle_pct         = 38;
        items_sent       = 0;
        settings_applied = 0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Dequeue from the empty queue
        send_item(ACT_DEQUEUE, '1);
        // Fill every slot at full capacity, so no unwritten slot is read later
        send_item(ACT_ENQUEUE, '0);
        send_item(ACT_ENQUEUE, '1);
        send_item(ACT_ENQUEUE, 64'h5555_5555_5555_5555);
        send_item(ACT_ENQUEUE, 64'hAAAA_AAAA_AAAA_AAAA);
        for (int i = 4; i < 16; i++)
            send_item(ACT_ENQUEUE, {$urandom, $urandom} ^ (64'h1 << (i * 4)));
        // Reject when full, then free one slot and fill it again
        send_item(ACT_ENQUEUE, pick_word());
        send_item(ACT_DEQUEUE, pick_word());
        send_item(ACT_ENQUEUE, pick_word());

        // Capacity of zero acts as one while sixteen messages are held
        drain_replies();
        write_reg(REG_FULL_POLICY, 5'd1);
        write_reg(REG_QUEUE_CAPACITY, 5'd0);
        send_item(ACT_ENQUEUE, pick_word());
        send_item(ACT_ENQUEUE, pick_word());
        send_item(ACT_DEQUEUE, pick_word());

        // Capacity above the slot count acts as the slot count
        drain_replies();
        write_reg(REG_QUEUE_CAPACITY, 5'd31);
        send_item(ACT_ENQUEUE, pick_word());
        send_item(ACT_ENQUEUE, pick_word());

        // Random phases, each under its own capacity and policy
        target    = items_sent + RANDOM_ITEMS;
        phase_idx = 0;
        while (items_sent < target)
        begin
            drain_replies();
            case ($urandom_range(7))
                0:       cap_value = 5'd0;
                1:       cap_value = 5'd1;
                2:       cap_value = 5'd16;
                3:       cap_value = 5'd31;
                default: cap_value = CAP_W'($urandom_range(31));
            endcase
            write_reg(REG_QUEUE_CAPACITY, cap_value);
            write_reg(REG_FULL_POLICY, CAP_W'($urandom_range(31)));
            if (phase_idx == 4)
            begin
                idle_pct  = 0;
                phase_len = 300;
            end
            else
            begin
                idle_pct  = 38;
                phase_len = $urandom_range(10, 60);
            end
            enq_pct = $urandom_range(20, 85);
            repeat (phase_len)
                send_item(($urandom_range(99) < enq_pct) ? ACT_ENQUEUE : ACT_DEQUEUE,
                          pick_word());
            phase_idx++;
        end

        // Let the last replies arrive
        drain_replies();
        repeat (4) @(negedge clk);

        $display("summary: %0d items under %0d register writes, %0d replies checked",
                 items_sent, settings_applied, replies_checked);
        $display("summary: status codes seen (empty..stored) %b, %0d mismatches",
                 statuses_seen, mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/mmq_pkg.sv
rtl/core/mmq_ram.sv
rtl/core/message_mailbox_queue_with_full_policy_core.sv
rtl/core/mmq_checker.sv
tb/message_mailbox_queue_with_full_policy_core_checker.sv
tb/message_mailbox_queue_with_full_policy_core_test.sv
